### sv/dcpb_pkg.sv
// ----------------------------------------------------------------------------
// dcpb_pkg
// constants, register codes and helpers for the dot crawl pixel blend unit
// ----------------------------------------------------------------------------
package dcpb_pkg;

	localparam int unsigned PixW       = 8;
	localparam int unsigned ColW       = 3 * PixW;
	localparam int unsigned AddrW      = 4;
	localparam int unsigned DataW      = 32;

	localparam int unsigned SpatThrW   = 10;
	localparam int unsigned WeightMaxW = 8;
	localparam int unsigned TempThrW   = 9;

	localparam logic [SpatThrW-1:0]   SpatThrReset   = 10'd12;
	localparam logic [WeightMaxW-1:0] WeightMaxReset = 8'd12;
	localparam logic [TempThrW-1:0]   TempThrReset   = 9'd0;

	localparam int unsigned FullWeight = 8192;
	localparam int unsigned MultW      = 14;
	localparam int unsigned RecipShift = 16;
	localparam logic [12:0] Recip10    = 13'd6554;
	localparam int unsigned OutShift   = 15;
	localparam logic [7:0]  PixMax     = 8'd255;

	typedef enum logic [1:0] {
		RegSpatialThr  = 2'd0,
		RegWeightMax   = 2'd1,
		RegTemporalThr = 2'd2
	} reg_idx_t;

	function automatic logic [PixW-1:0] row_px(input logic [ColW-1:0] col, input logic [1:0] row);
		row_px = col[PixW*row +: PixW];
	endfunction

	function automatic logic [PixW-1:0] abs_diff(input logic [PixW-1:0] a, input logic [PixW-1:0] b);
		abs_diff = (a > b) ? a - b : b - a;
	endfunction

	// weighted column sum: top + 2*center + bottom
	function automatic logic [9:0] col_sum(input logic [ColW-1:0] col);
		col_sum = 10'(col[7:0]) + {1'b0, col[15:8], 1'b0} + 10'(col[23:16]);
	endfunction

endpackage

### sv/dot_crawl_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// dot_crawl_pixel_blend_unit
// spatio-temporal dot crawl filter, one 8-bit pixel per item
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries the pixel window: three current
//   frame columns, the previous and next frame columns, and the pixels two
//   frames back and ahead. output channel out_valid/out_ready carries
//   filtered_pixel, one result per input item, in order.
//   the datapath is a five stage pipeline: sums, weight levels and the
//   divide-by-ten product, weights and spatial estimate, blend products,
//   final add and clamp into the output register. throughput is one item
//   per cycle while the receiver keeps out_ready high.
//   each stage holds its own valid bit and loads whenever it is empty or its
//   successor moves, so a stalled receiver fills the pipeline without loss
//   and empty stages still take new items.
//   the apb port reaches the three registers at 0x0, 0x4 and 0x8; writes are
//   expected only while the pipeline is empty.
//   reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module dot_crawl_pixel_blend_unit (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dcpb_pkg::AddrW-1:0]      paddr,
	input  logic [dcpb_pkg::DataW-1:0]      pwdata,
	output logic [dcpb_pkg::DataW-1:0]      prdata,
	output logic                            pready,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dcpb_pkg::ColW-1:0]       cur_left_column,
	input  logic [dcpb_pkg::ColW-1:0]       cur_center_column,
	input  logic [dcpb_pkg::ColW-1:0]       cur_right_column,
	input  logic [dcpb_pkg::ColW-1:0]       prev_column,
	input  logic [dcpb_pkg::ColW-1:0]       next_column,
	input  logic [dcpb_pkg::PixW-1:0]       prev2_pixel,
	input  logic [dcpb_pkg::PixW-1:0]       next2_pixel,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dcpb_pkg::PixW-1:0]       filtered_pixel
);
	import dcpb_pkg::*;

	// configuration
	logic [SpatThrW-1:0]   spat_thr_q;
	logic [WeightMaxW-1:0] weight_max_q;
	logic [TempThrW-1:0]   temp_thr_q;
	logic [MultW-1:0]      mult_q;
	logic [MultW-1:0]      mult_tab [2**WeightMaxW];
	logic [WeightMaxW-1:0] tmax;
	logic [8:0]            tlim;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	assign mult_tab[0] = MultW'(FullWeight);
	for (genvar g = 1; g < 2**WeightMaxW; g++) begin : g_mult
		localparam int unsigned Mult = FullWeight / g;
		assign mult_tab[g] = MultW'(Mult);
	end

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spat_thr_q   <= SpatThrReset;
			weight_max_q <= WeightMaxReset;
			temp_thr_q   <= TempThrReset;
			mult_q       <= mult_tab[WeightMaxReset];
		end else if (cfg_wr) begin
			case (reg_idx)
				RegSpatialThr:  spat_thr_q <= pwdata[SpatThrW-1:0];
				RegWeightMax: begin
					weight_max_q <= pwdata[WeightMaxW-1:0];
					mult_q       <= mult_tab[pwdata[WeightMaxW-1:0]];
				end
				RegTemporalThr: temp_thr_q <= pwdata[TempThrW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegSpatialThr:  prdata = DataW'(spat_thr_q);
			RegWeightMax:   prdata = DataW'(weight_max_q);
			RegTemporalThr: prdata = DataW'(temp_thr_q);
			default:        prdata = '0;
		endcase
	end

	assign tmax = (weight_max_q == '0) ? WeightMaxW'(1) : weight_max_q;
	assign tlim = 9'(tmax) + 9'd1;

	// weight level: clamp(sthr + tmax - |diff|, 0, tmax + 1)
	function automatic logic [8:0] weight_level(input logic [9:0] a, input logic [9:0] b,
			input logic [SpatThrW-1:0] sthr, input logic [WeightMaxW-1:0] tm,
			input logic [8:0] lim);
		logic [9:0]        ad;
		logic [10:0]       base;
		logic signed [11:0] d;
		ad   = (a > b) ? a - b : b - a;
		base = 11'(sthr) + 11'(tm);
		d    = $signed({1'b0, base}) - $signed({2'b0, ad});
		if (d < 0)
			weight_level = '0;
		else if (d[10:0] > 11'(lim))
			weight_level = lim;
		else
			weight_level = d[8:0];
	endfunction

	// stage enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: sums, temporal test, plain average
	logic [PixW-1:0]   cur, p1, n1, ad_pn, ad_pc, ad_cn;
	logic [9:0]        ccs_c, avg_sum;
	logic [12:0]       pos_c;
	logic [9:0]        neg_c;
	logic [9:0]        ccs_s1, ncs_s1, pcs_s1;
	logic signed [13:0] num_s1;
	logic              fast_s1;
	logic [PixW-1:0]   avg_s1;
	logic [8:0]        cp_s1, cn_s1;

	always_comb begin
		cur     = row_px(cur_center_column, 2'd1);
		p1      = row_px(prev_column, 2'd1);
		n1      = row_px(next_column, 2'd1);
		ad_pn   = abs_diff(p1, n1);
		ad_pc   = abs_diff(prev2_pixel, cur);
		ad_cn   = abs_diff(cur, next2_pixel);
		ccs_c   = col_sum(cur_center_column);
		pos_c   = 13'({row_px(cur_left_column, 2'd1), 1'b0})
			+ 13'({row_px(cur_right_column, 2'd1), 1'b0})
			+ 13'({ccs_c, 1'b0}) + 13'({cur, 3'b0}) + 13'({cur, 2'b0});
		neg_c   = 10'(row_px(cur_left_column, 2'd0)) + 10'(row_px(cur_right_column, 2'd0))
			+ 10'(row_px(cur_left_column, 2'd2)) + 10'(row_px(cur_right_column, 2'd2));
		avg_sum = 10'(p1) + {1'b0, cur, 1'b0} + 10'(n1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en_s1)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ccs_s1  <= ccs_c;
			ncs_s1  <= col_sum(next_column);
			pcs_s1  <= col_sum(prev_column);
			num_s1  <= $signed({1'b0, pos_c}) - $signed({4'b0, neg_c});
			fast_s1 <= ({1'b0, ad_pn} < temp_thr_q) && ({1'b0, ad_pc} < temp_thr_q)
				&& ({1'b0, ad_cn} < temp_thr_q);
			avg_s1  <= avg_sum[9:2];
			cp_s1   <= 9'(cur) + 9'(p1);
			cn_s1   <= 9'(cur) + 9'(n1);
		end
	end

	// stage 2: weight levels, magnitude times reciprocal of ten
	logic [12:0] mag_c;
	logic [8:0]  nl_s2, pl_s2;
	logic [25:0] qprod_s2;
	logic        neg_s2, fast_s2;
	logic [PixW-1:0] avg_s2;
	logic [8:0]  cp_s2, cn_s2;

	assign mag_c = num_s1[13] ? 13'(-num_s1) : num_s1[12:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			nl_s2    <= weight_level(ncs_s1, ccs_s1, spat_thr_q, tmax, tlim);
			pl_s2    <= weight_level(pcs_s1, ccs_s1, spat_thr_q, tmax, tlim);
			qprod_s2 <= 26'(mag_c) * 26'(Recip10);
			neg_s2   <= num_s1[13];
			fast_s2  <= fast_s1;
			avg_s2   <= avg_s1;
			cp_s2    <= cp_s1;
			cn_s2    <= cn_s1;
		end
	end

	// stage 3: weights and spatial estimate
	logic [22:0] nw_full, pw_full;
	logic [9:0]  quot_c;
	logic [MultW-1:0] nw_s3, pw_s3;
	logic signed [10:0] spatial_s3;
	logic        fast_s3;
	logic [PixW-1:0] avg_s3;
	logic [8:0]  cp_s3, cn_s3;

	assign nw_full = 23'(nl_s2) * 23'(mult_q);
	assign pw_full = 23'(pl_s2) * 23'(mult_q);
	assign quot_c  = qprod_s2[RecipShift +: 10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en_s3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			nw_s3      <= (nw_full > 23'(FullWeight)) ? MultW'(FullWeight) : nw_full[MultW-1:0];
			pw_s3      <= (pw_full > 23'(FullWeight)) ? MultW'(FullWeight) : pw_full[MultW-1:0];
			spatial_s3 <= neg_s2 ? -$signed({1'b0, quot_c}) : $signed({1'b0, quot_c});
			fast_s3    <= fast_s2;
			avg_s3     <= avg_s2;
			cp_s3      <= cp_s2;
			cn_s3      <= cn_s2;
		end
	end

	// stage 4: blend products
	logic [14:0] cw_c;
	logic signed [25:0] cprod_s4;
	logic [22:0] pprod_s4, nprod_s4;
	logic        fast_s4;
	logic [PixW-1:0] avg_s4;

	assign cw_c = 15'(2 * FullWeight) - 15'(nw_s3) - 15'(pw_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en_s4)
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			cprod_s4 <= $signed({1'b0, cw_c}) * spatial_s3;
			pprod_s4 <= 23'(pw_s3) * 23'(cp_s3);
			nprod_s4 <= 23'(nw_s3) * 23'(cn_s3);
			fast_s4  <= fast_s3;
			avg_s4   <= avg_s3;
		end
	end

	// stage 5: sum, shift, clamp, select
	logic signed [26:0] sum_c;
	logic [PixW-1:0]    pix_c;
	logic [PixW-1:0]    pixel_s5;

	always_comb begin
		sum_c = 27'(cprod_s4) + $signed({4'b0, pprod_s4}) + $signed({4'b0, nprod_s4});
		if (fast_s4)
			pix_c = avg_s4;
		else if (sum_c < 0)
			pix_c = '0;
		else if (sum_c[25:OutShift+PixW] != '0)
			pix_c = PixMax;
		else
			pix_c = sum_c[OutShift +: PixW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (en_s5)
			valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4)
			pixel_s5 <= pix_c;
	end

	assign out_valid      = valid_s5;
	assign filtered_pixel = pixel_s5;

	// checks
	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused with an empty first stage");

	a_fast_needs_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fast_s1 |-> temp_thr_q != '0)
		else $error("plain average taken with a zero threshold");

	a_weight_capped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (nw_s3 <= MultW'(FullWeight)) && (pw_s3 <= MultW'(FullWeight)))
		else $error("temporal weight above full weight");

	a_spatial_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (spatial_s3 >= -11'sd102) && (spatial_s3 <= 11'sd612))
		else $error("spatial estimate out of range");

endmodule

### sim/dot_crawl_pixel_blend_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_crawl_pixel_blend_unit_tb
// self-checking bench for the dot crawl pixel blend unit: every accepted
// window is run through a cycle-free predictor of the temporal average and
// spatio-temporal blend, and each filtered pixel is compared in order.
// register settings are changed over apb between phases while the pipeline
// is empty and read back, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module dot_crawl_pixel_blend_unit_tb;
	import dcpb_pkg::*;

	typedef struct {
		logic [ColW-1:0] lcol;
		logic [ColW-1:0] ccol;
		logic [ColW-1:0] rcol;
		logic [ColW-1:0] pcol;
		logic [ColW-1:0] ncol;
		logic [PixW-1:0] p2;
		logic [PixW-1:0] n2;
	} pixel_window_t;

	class blend_scoreboard;
		localparam int FullW      = 8192;
		localparam int CenterGain = 12;
		localparam int SpatialDiv = 10;
		localparam int BlendShift = 15;
		localparam int PixTop     = 255;

		logic [SpatThrW-1:0]   spat_thr;
		logic [WeightMaxW-1:0] weight_max;
		logic [TempThrW-1:0]   temp_thr;
		logic [PixW-1:0]       pixel_q[$];
		int                    errors;

		function new();
			spat_thr   = SpatThrReset;
			weight_max = WeightMaxReset;
			temp_thr   = TempThrReset;
			errors     = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
			RegSpatialThr: begin
				spat_thr = value[SpatThrW-1:0];
			end
			RegWeightMax: begin
				weight_max = value[WeightMaxW-1:0];
			end
			RegTemporalThr: begin
				temp_thr = value[TempThrW-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
			RegSpatialThr:  return 32'(spat_thr);
			RegWeightMax:   return 32'(weight_max);
			default:        return 32'(temp_thr);
			endcase
		endfunction

		function void mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
		endfunction

		function int row(logic [ColW-1:0] col, int r);
			return int'(col[PixW*r +: PixW]);
		endfunction

		function int absd(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		function int col_weighted(logic [ColW-1:0] col);
			return row(col, 0) + 2 * row(col, 1) + row(col, 2);
		endfunction

		function int temporal_wt(int coldiff, int tmax, int mult);
			int d;
			int w;
			d = int'(spat_thr) + tmax - absd(coldiff, 0);
			if (d < 0)
				d = 0;
			else if (d > tmax + 1)
				d = tmax + 1;
			w = d * mult;
			return (w > FullW) ? FullW : w;
		endfunction

		function logic [PixW-1:0] blend_pixel(pixel_window_t w);
			int cur, p1, n1, p2, n2, tthr;
			int tmax, mult, ccs, spatial, nw, pw, cw, sum, res;
			cur  = row(w.ccol, 1);
			p1   = row(w.pcol, 1);
			n1   = row(w.ncol, 1);
			p2   = int'(w.p2);
			n2   = int'(w.n2);
			tthr = int'(temp_thr);
			if (absd(p1, n1) < tthr && absd(p2, cur) < tthr && absd(cur, n2) < tthr) begin
				res = (p1 + 2 * cur + n1) >> 2;
			end else begin
				tmax    = (weight_max == 0) ? 1 : int'(weight_max);
				mult    = FullW / tmax;
				ccs     = col_weighted(w.ccol);
				spatial = (-row(w.lcol, 0) - row(w.rcol, 0)
					+ 2 * row(w.lcol, 1) + 2 * row(w.rcol, 1)
					- row(w.lcol, 2) - row(w.rcol, 2)
					+ 2 * ccs + CenterGain * cur) / SpatialDiv;
				nw  = temporal_wt(col_weighted(w.ncol) - ccs, tmax, mult);
				pw  = temporal_wt(col_weighted(w.pcol) - ccs, tmax, mult);
				cw  = 2 * FullW - (nw + pw);
				sum = cw * spatial + pw * (cur + p1) + nw * (cur + n1);
				if (sum < 0)
					res = 0;
				else begin
					res = sum >>> BlendShift;
					if (res > PixTop)
						res = PixTop;
				end
			end
			return res[PixW-1:0];
		endfunction

		function void note_window(pixel_window_t w);
			pixel_q.push_back(blend_pixel(w));
		endfunction

		function void check_pixel(logic [PixW-1:0] got);
			logic [PixW-1:0] want;
			if (pixel_q.size() == 0) begin
				mismatch("pixel with none pending", 0, 32'(got));
				return;
			end
			want = pixel_q.pop_front();
			if (got !== want)
				mismatch("filtered_pixel", 32'(want), 32'(got));
		endfunction
	endclass

	localparam int Latency    = 5;
	localparam int CycleLimit = 1000000;
	localparam int PhaseItems = 190;
	localparam int HoldCycles = 80;
	localparam logic [AddrW-1:0] UnusedAddr = 4'hC;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             in_valid;
	logic             in_ready;
	logic [ColW-1:0]  cur_left_column;
	logic [ColW-1:0]  cur_center_column;
	logic [ColW-1:0]  cur_right_column;
	logic [ColW-1:0]  prev_column;
	logic [ColW-1:0]  next_column;
	logic [PixW-1:0]  prev2_pixel;
	logic [PixW-1:0]  next2_pixel;
	logic             out_valid;
	logic             out_ready;
	logic [PixW-1:0]  filtered_pixel;

	blend_scoreboard sb = new();
	pixel_window_t   taken_window;
	logic            hold_off_req = 1'b0;
	int              cycle_count = 0;

	dot_crawl_pixel_blend_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cur_left_column   (cur_left_column),
		.cur_center_column (cur_center_column),
		.cur_right_column  (cur_right_column),
		.prev_column       (prev_column),
		.next_column       (next_column),
		.prev2_pixel       (prev2_pixel),
		.next2_pixel       (next2_pixel),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.filtered_pixel    (filtered_pixel)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready) begin
				taken_window.lcol = cur_left_column;
				taken_window.ccol = cur_center_column;
				taken_window.rcol = cur_right_column;
				taken_window.pcol = prev_column;
				taken_window.ncol = next_column;
				taken_window.p2   = prev2_pixel;
				taken_window.n2   = next2_pixel;
				sb.note_window(taken_window);
			end
			if (out_valid && out_ready)
				sb.check_pixel(filtered_pixel);
		end
		if (cycle_count >= CycleLimit) begin
			$display("dot_crawl_pixel_blend_unit_tb: errors");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PixW-1:0] random_px(int mode, int base, int spread);
		int v;
		case (mode)
		0: return PixW'($urandom_range(0, 255));
		1: begin
			v = base + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			else if (v > 255)
				v = 255;
			return v[PixW-1:0];
		end
		default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// random, smooth and black-and-white neighborhoods so that both paths and partial weights show up
	function automatic pixel_window_t random_window();
		pixel_window_t w;
		int r, mode, base, spread;
		r = $urandom_range(0, 99);
		mode = (r < 40) ? 0 : (r < 85) ? 1 : 2;
		base = $urandom_range(0, 255);
		case ($urandom_range(0, 3))
		0:       spread = 1;
		1:       spread = 4;
		2:       spread = 16;
		default: spread = 48;
		endcase
		w.lcol = {random_px(mode, base, spread), random_px(mode, base, spread),
			random_px(mode, base, spread)};
		w.ccol = {random_px(mode, base, spread), random_px(mode, base, spread),
			random_px(mode, base, spread)};
		w.rcol = {random_px(mode, base, spread), random_px(mode, base, spread),
			random_px(mode, base, spread)};
		w.pcol = {random_px(mode, base, spread), random_px(mode, base, spread),
			random_px(mode, base, spread)};
		w.ncol = {random_px(mode, base, spread), random_px(mode, base, spread),
			random_px(mode, base, spread)};
		w.p2   = random_px(mode, base, spread);
		w.n2   = random_px(mode, base, spread);
		return w;
	endfunction

	function automatic pixel_window_t pack_window(logic [ColW-1:0] l, logic [ColW-1:0] c,
		logic [ColW-1:0] r, logic [ColW-1:0] p, logic [ColW-1:0] n,
		logic [PixW-1:0] p2, logic [PixW-1:0] n2);
		pixel_window_t w;
		w.lcol = l;
		w.ccol = c;
		w.rcol = r;
		w.pcol = p;
		w.ncol = n;
		w.p2   = p2;
		w.n2   = n2;
		return w;
	endfunction

	task automatic send_window(pixel_window_t w, int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		cur_left_column   <= w.lcol;
		cur_center_column <= w.ccol;
		cur_right_column  <= w.rcol;
		prev_column       <= w.pcol;
		next_column       <= w.ncol;
		prev2_pixel       <= w.p2;
		next2_pixel       <= w.n2;
		in_valid          <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_idle(int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pixel_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
		input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned value);
		logic [DataW-1:0] data, mask, junk;
		int wid;
		case (idx)
		RegSpatialThr: wid = SpatThrW;
		RegWeightMax:  wid = WeightMaxW;
		default:       wid = TempThrW;
		endcase
		mask = (32'd1 << wid) - 32'd1;
		data = value & mask;
		if ($urandom_range(0, 1))
			data |= $urandom() & ~mask;
		apb_access(1'b1, {idx, 2'b00}, data, junk);
		sb.set_reg(idx, data);
	endtask

	task automatic readback();
		reg_idx_t idx;
		logic [DataW-1:0] rd;
		for (int i = 0; i < 3; i++) begin
			idx = reg_idx_t'(i);
			apb_access(1'b0, {idx, 2'b00}, '0, rd);
			if (rd !== sb.reg_value(idx))
				sb.mismatch("register readback", sb.reg_value(idx), rd);
		end
	endtask

	task automatic configure(int unsigned st, int unsigned wm, int unsigned tt);
		logic [DataW-1:0] junk;
		wait_idle(Latency + 3);
		write_reg(RegSpatialThr, st);
		write_reg(RegWeightMax, wm);
		write_reg(RegTemporalThr, tt);
		apb_access(1'b1, UnusedAddr, $urandom(), junk);
		readback();
	endtask

	// receiver: random ready with one long hold-off on request
	initial begin : receiver
		int run;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				repeat (HoldCycles) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
			repeat (run) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
			gap = gap_len();
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int dense_left;
		int chunk_left;
		logic idle_on;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		in_valid          = 1'b0;
		cur_left_column   = '0;
		cur_center_column = '0;
		cur_right_column  = '0;
		prev_column       = '0;
		next_column       = '0;
		prev2_pixel       = '0;
		next2_pixel       = '0;
		dense_left        = 0;
		chunk_left        = 0;
		idle_on           = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		readback();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
			0: begin
				// reset settings: blend path only
				send_window(pack_window('0, '0, '0, '0, '0, '0, '0), gap_len());
				send_window(pack_window(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
					24'hFFFFFF, 8'hFF, 8'hFF), gap_len());
				// negative spatial estimate, no temporal weight
				send_window(pack_window(24'hFF00FE, 24'h000000, 24'hFF00FF, 24'hFFFFFF,
					24'hFFFFFF, 8'h00, 8'h00), gap_len());
				// blend far above full scale
				send_window(pack_window(24'h00FF00, 24'hFFFFFF, 24'h00FF00, 24'h000000,
					24'h000000, 8'h00, 8'h00), gap_len());
				send_window(pack_window(24'hFFFFFF, '0, '0, '0, '0, '0, '0), gap_len());
				send_window(pack_window('0, 24'hFFFFFF, '0, '0, '0, '0, '0), gap_len());
				send_window(pack_window('0, '0, 24'hFFFFFF, '0, '0, '0, '0), gap_len());
				send_window(pack_window('0, '0, '0, 24'hFFFFFF, '0, '0, '0), gap_len());
				send_window(pack_window('0, '0, '0, '0, 24'hFFFFFF, '0, '0), gap_len());
				send_window(pack_window('0, '0, '0, '0, '0, 8'hFF, '0), gap_len());
				send_window(pack_window('0, '0, '0, '0, '0, '0, 8'hFF), gap_len());
			end
			1: begin
				// weight limit zero, widest averaging threshold
				configure(1023, 0, 256);
				send_window(pack_window(24'h808080, 24'h808080, 24'h808080, 24'h808080,
					24'h808080, 8'h80, 8'h80), gap_len());
				send_window(pack_window(24'h000000, 24'h00FF00, 24'h000000, 24'h000000,
					24'h00FF00, 8'h00, 8'hFF), gap_len());
				send_window(pack_window(24'h12AB34, 24'h5A3C7E, 24'hF00F0F, 24'h33CC33,
					24'h0081FF, 8'h01, 8'hFE), gap_len());
			end
			2: begin
				// threshold one: only exact temporal matches average
				configure(0, 1, 1);
				send_window(pack_window(24'h123456, 24'h305030, 24'h789ABC, 24'h105020,
					24'h205010, 8'h50, 8'h50), gap_len());
				send_window(pack_window(24'h123456, 24'h305030, 24'h789ABC, 24'h105020,
					24'h205010, 8'h51, 8'h50), gap_len());
				send_window(pack_window(24'h123456, 24'h305030, 24'h789ABC, 24'h105020,
					24'h205010, 8'h50, 8'h4F), gap_len());
				send_window(pack_window(24'h123456, 24'h305030, 24'h789ABC, 24'h105020,
					24'h205110, 8'h50, 8'h50), gap_len());
				hold_off_req = 1'b1;
				dense_left = 150;
			end
			3: configure(1023, 255, 511);
			4: configure(0, 255, 0);
			default: begin
				configure($urandom_range(0, 1023), $urandom_range(1, 255),
					$urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 511));
			end
			endcase

			for (int k = 0; k < PhaseItems; k++) begin
				if (phase == 4 && k == PhaseItems / 2)
					wait_idle(0);
				if (chunk_left == 0) begin
					idle_on = ($urandom_range(0, 3) != 0);
					chunk_left = $urandom_range(10, 60);
				end
				chunk_left--;
				if (dense_left > 0) begin
					dense_left--;
					send_window(random_window(), 0);
				end else
					send_window(random_window(), idle_on ? gap_len() : 0);
			end
		end

		wait_idle(Latency + 5);
		if (sb.errors == 0)
			$display("dot_crawl_pixel_blend_unit_tb: clean");
		else
			$display("dot_crawl_pixel_blend_unit_tb: errors");
		$finish;
	end

endmodule
